// ===== rtl/core/sts_pkg.sv =====
package sts_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_PROBE = 1'b1
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [INDEX_W-1:0]   index;
    } t_result;

endpackage

// ===== rtl/core/sts_table.sv =====
module sts_table import sts_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic signed [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sts_search.sv =====
module sts_search import sts_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8,
    parameter int CNT_W = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_op,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic signed [VALUE_W-1:0] i_search_key,
    input  logic [COUNT_W-1:0]        i_entry_count,
    output logic                      o_we,
    output logic [ADDR_W-1:0]         o_waddr,
    output logic signed [VALUE_W-1:0] o_wdata,
    output logic                      o_re,
    output logic [ADDR_W-1:0]         o_raddr,
    input  logic signed [VALUE_W-1:0] i_rdata,
    output t_result                   o_result
);

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_low, n_low;
    logic [CNT_W-1:0]          r_end, n_end;
    logic [ADDR_W-1:0]         r_mid, n_mid;
    logic signed [VALUE_W-1:0] r_key, n_key;
    t_result                   r_result, n_result;

    logic                      accept;
    logic                      is_search;
    logic [31:0]               count_sat;
    logic [CNT_W-1:0]          count;
    logic                      hit;
    logic                      entry_lt;
    logic                      more;
    logic [CNT_W:0]            mid_sum;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign is_search = (t_op'(i_op) == OP_SEARCH);
    assign count_sat = (32'(i_entry_count) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(i_entry_count);
    assign count     = CNT_W'(count_sat);
    assign hit       = (i_rdata == r_key);
    assign entry_lt  = (i_rdata < r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_search && (count != '0)) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (hit || !more) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // search window update and the next probe address
    always_comb begin
        n_low    = r_low;
        n_end    = r_end;
        n_key    = r_key;
        n_result = '0;
        o_re     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_low = '0;
                n_end = count;
                n_key = i_search_key;
                if (accept && is_search && (count == '0)) begin
                    n_result.valid = 1'b1;
                end
            end
            ST_PROBE: begin
                if (entry_lt) begin
                    n_low = CNT_W'(r_mid) + CNT_W'(1);
                end else begin
                    n_end = CNT_W'(r_mid);
                end
                if (hit) begin
                    n_result.valid = 1'b1;
                    n_result.found = 1'b1;
                    n_result.index = INDEX_W'(r_mid);
                end else if (!more) begin
                    n_result.valid = 1'b1;
                end
            end
            default: begin
                n_low = r_low;
            end
        endcase
        // midpoint of [low, end-1], only used while the window is non-empty
        mid_sum = {1'b0, n_low} + {1'b0, n_end} - (CNT_W+1)'(1);
        n_mid   = ADDR_W'(mid_sum >> 1);
        more    = (n_low < n_end);
        if (r_state == ST_IDLE) begin
            o_re = accept && is_search && more;
        end else begin
            o_re = !hit && more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low <= n_low;
        r_end <= n_end;
        r_key <= n_key;
        if (o_re) begin
            r_mid <= n_mid;
        end
    end

    assign o_raddr  = n_mid;
    assign o_we     = accept && !is_search && (32'(i_entry_index) < 32'(DEPTH));
    assign o_waddr  = ADDR_W'(i_entry_index);
    assign o_wdata  = i_entry_value;
    assign o_busy   = (r_state != ST_IDLE);
    assign o_result = r_result;

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
// Sorted table with binary search. Load entries in ascending signed order with
// write transactions (op = 0), set the entry count on the config channel, then
// issue search transactions (op = 1). A write gives no result.
// A search probes one table entry per cycle through the table's single read port,
// so it holds busy while it makes its probes (at most floor(log2(n))+1 probes for
// n entries, 9 for a full 256-entry table); an empty table answers right away.
// The result appears for exactly one cycle with o_result_valid, registered from
// the compare of the last probe, and cannot be held off. The table comes up
// undefined and needs no clearing after reset; searching entries that were never
// written gives undefined results. Entry writes beyond the table depth are
// dropped and an entry count above the depth is clipped to it.
module sorted_table_binary_search import sts_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_op,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic signed [VALUE_W-1:0] i_search_key,
    output logic                      o_result_valid,
    output logic                      o_found,
    output logic [INDEX_W-1:0]        o_found_index,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [COUNT_W-1:0]        i_cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0]        r_entry_count;
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic                      re;
    logic [ADDR_W-1:0]         raddr;
    logic signed [VALUE_W-1:0] rdata;
    t_result                   result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entry_count <= i_cfg_data;
        end
    end

    sts_search #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_entry_count (r_entry_count),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_re          (re),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_result      (result)
    );

    sts_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_result_valid = result.valid;
    assign o_found        = result.found;
    assign o_found_index  = result.index;

endmodule

// ===== test/tb_sorted_table_binary_search.sv =====
module tb_sorted_table_binary_search;
    import sts_pkg::*;

    localparam int TABLE_SIZE    = 256;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } t_search_answer;

    class search_tracker;
        int               entries [TABLE_SIZE];
        logic [COUNT_W-1:0] entry_count;
        t_search_answer   pending_answers [$];
        int               errors;
        int               writes;
        int               searches;
        int               hits;

        function new();
            entry_count = '0;
            errors      = 0;
            writes      = 0;
            searches    = 0;
            hits        = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] count);
            entry_count = count;
        endfunction

        function int pending_count();
            return pending_answers.size();
        endfunction

        // probes mid = (lo + hi) / 2 until a hit or the window closes
        function t_search_answer predict_search(int key);
            t_search_answer answer;
            int lo;
            int hi;
            int mid;
            answer.found = 1'b0;
            answer.index = '0;
            lo = 0;
            hi = ((entry_count > TABLE_SIZE) ? TABLE_SIZE : int'(entry_count)) - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (entries[mid] == key) begin
                    answer.found = 1'b1;
                    answer.index = mid[INDEX_W-1:0];
                    break;
                end else if (entries[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            return answer;
        endfunction

        function void note_item(t_op op, logic [INDEX_W-1:0] index, int value, int key);
            t_search_answer answer;
            if (op == OP_WRITE) begin
                entries[index] = value;
                writes++;
            end else begin
                answer = predict_search(key);
                pending_answers.push_back(answer);
                searches++;
                if (answer.found) hits++;
            end
        endfunction

        function void check(logic found, logic [INDEX_W-1:0] index);
            t_search_answer want;
            if (pending_answers.size() == 0) begin
                $display("%0t: result with no search outstanding, expected none, actual found %0d index %0d",
                         $time, found, index);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (found !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, found);
                errors++;
            end
            if (index !== want.index) begin
                $display("%0t: found_index expected %0d actual %0d", $time, want.index, index);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_start       = 1'b0;
    logic                      o_busy;
    logic                      i_op          = 1'b0;
    logic [INDEX_W-1:0]        i_entry_index = '0;
    logic signed [VALUE_W-1:0] i_entry_value = '0;
    logic signed [VALUE_W-1:0] i_search_key  = '0;
    logic                      o_result_valid;
    logic                      o_found;
    logic [INDEX_W-1:0]        o_found_index;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [COUNT_W-1:0]        i_cfg_data    = '0;

    search_tracker tracker;
    bit            written [TABLE_SIZE];
    int            items_sent  = 0;
    int            random_base = -1;
    int            settings    = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_SIZE)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_search_key   (i_search_key),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_found_index  (o_found_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) tracker.check(o_found, o_found_index);
    end

    task automatic send_item(t_op op, logic [INDEX_W-1:0] index, int value, int key);
        int done;
        int idle_pct;
        done     = items_sent - random_base;
        idle_pct = (random_base < 0) ? 0 :
                   (done < RANDOM_ITEMS / 3) ? 9 :
                   (done < 2 * RANDOM_ITEMS / 3) ? 84 : 0;
        // each idle cycle is drawn on its own
        if (idle_pct > 0) begin
            while ($urandom_range(99) < idle_pct) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start       <= 1'b1;
        i_op          <= op;
        i_entry_index <= index;
        i_entry_value <= value;
        i_search_key  <= key;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        tracker.note_item(op, index, value, key);
        if (op == OP_WRITE) written[index] = 1'b1;
        items_sent++;
    endtask

    // hold off new transactions until every search has answered
    task automatic drain();
        i_start <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_entry_count(logic [COUNT_W-1:0] count);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.set_count(count);
        settings++;
    endtask

    initial begin
        int seed_vals [8];
        int vals [$];
        int order [$];
        int n;
        int cnt;
        int span;
        int pick;
        int key;
        int phase;
        int prefix;
        bit narrow;
        bit paused;

        seed_vals = '{32'h80000000, -7, -1, 0, 0, 3, 1000, 32'h7fffffff};
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table answers not found without probing
        send_item(OP_SEARCH, '0, 0, 0);
        for (int i = 0; i < 8; i++)
            send_item(OP_WRITE, INDEX_W'(i), seed_vals[i], $urandom);
        write_entry_count(COUNT_W'(8));
        send_item(OP_SEARCH, '0, 0, 32'h80000000);
        send_item(OP_SEARCH, '0, 0, 32'h7fffffff);
        send_item(OP_SEARCH, '0, 0, 0);
        send_item(OP_SEARCH, '0, 0, 2);
        send_item(OP_SEARCH, '0, 0, 32'h80000001);
        send_item(OP_SEARCH, '0, 0, 32'h7ffffffe);
        write_entry_count(COUNT_W'(1));
        send_item(OP_SEARCH, '0, 0, 32'h80000000);
        send_item(OP_SEARCH, '0, 0, 3);
        // break the ordering and search anyway
        send_item(OP_WRITE, INDEX_W'(2), 32'h7fffffff, 0);
        write_entry_count(COUNT_W'(8));
        send_item(OP_SEARCH, '0, 0, -1);
        send_item(OP_SEARCH, '0, 0, 32'h7fffffff);
        send_item(OP_WRITE, 8'hff, $urandom, $urandom);

        random_base = items_sent;
        phase       = 0;
        paused      = 1'b0;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            if (phase == 1) begin
                n = TABLE_SIZE;
            end else begin
                pick = $urandom_range(99);
                n = (pick < 10) ? 0 : (pick < 25) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            end
            narrow = ($urandom_range(3) == 0);
            vals.delete();
            order.delete();
            for (int i = 0; i < n; i++) begin
                vals.push_back(narrow ? int'($urandom_range(40)) - 20 : int'($urandom));
                order.push_back(i);
            end
            if ($urandom_range(9) != 0) vals.sort();
            order.shuffle();
            foreach (order[k])
                send_item(OP_WRITE, INDEX_W'(order[k]), vals[order[k]], $urandom);

            for (int s = 0; s < 2; s++) begin
                prefix = 0;
                while (prefix < TABLE_SIZE && written[prefix]) prefix++;
                if (s == 0) cnt = n;
                else if (phase == 1) cnt = 511;
                else if (prefix == TABLE_SIZE && $urandom_range(1)) cnt = $urandom_range(256, 511);
                else cnt = $urandom_range(0, prefix);
                write_entry_count(COUNT_W'(cnt));
                span = (cnt > TABLE_SIZE) ? TABLE_SIZE : cnt;
                repeat ($urandom_range(6, 20)) begin
                    pick = $urandom_range(99);
                    if (pick < 15) begin
                        send_item(OP_WRITE, INDEX_W'($urandom), $urandom, $urandom);
                    end else begin
                        if (span > 0 && pick < 70)
                            key = tracker.entries[$urandom_range(0, span - 1)];
                        else if (span > 0 && pick < 80)
                            key = tracker.entries[$urandom_range(0, span - 1)]
                                  + ($urandom_range(1) ? 1 : -1);
                        else if (pick < 88)
                            key = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
                        else
                            key = $urandom;
                        send_item(OP_SEARCH, INDEX_W'($urandom), $urandom, key);
                    end
                    if (!paused && items_sent - random_base > RANDOM_ITEMS / 2) begin
                        paused = 1'b1;
                        drain();
                    end
                end
            end
            phase++;
        end

        drain();
        $display("Run covered %0d table writes and %0d searches (%0d hits) over %0d count settings",
                 tracker.writes, tracker.searches, tracker.hits, settings);
        if (tracker.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sts_pkg.sv
rtl/core/sts_table.sv
rtl/core/sts_search.sv
rtl/core/sorted_table_binary_search.sv
test/tb_sorted_table_binary_search.sv
